FILE: hdl/pmt_pkg.sv
// Package for the PS/2 mouse packet tracker: word types, packet flag bits,
// register indexes, reset values and the delta decode function.
// Depends on nothing; every other file of the block takes its names from here.
package pmt_pkg;

	// Input word: a mouse byte or a millisecond tick.
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_word_t;

	// Result word: one per completed packet.
	typedef struct packed {
		logic [11:0] cursor_x;
		logic [11:0] cursor_y;
		logic [2:0]  buttons;
		logic [2:0]  clicks;
		logic [2:0]  holds;
	} out_word_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Bit positions in the packet head byte.
	localparam int SYNC_POS  = 3;
	localparam int XSIGN_POS = 4;
	localparam int YSIGN_POS = 5;
	localparam int XOVF_POS  = 6;
	localparam int YOVF_POS  = 7;

	localparam int CURSOR_W = 12;
	localparam int HOLD_W   = 16;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_X   = 2'd0,
		REG_MAX_Y   = 2'd1,
		REG_HOLD_MS = 2'd2
	} cfg_reg_t;

	localparam logic [11:0] MAX_X_RESET   = 12'd1008;
	localparam logic [11:0] MAX_Y_RESET   = 12'd752;
	localparam logic [15:0] HOLD_MS_RESET = 16'd100;
	localparam int          POS_RESET     = 50;

	localparam logic signed [9:0] OVF_EXTRA = 10'sd255;
	localparam logic [15:0]       HELD_SAT  = 16'hFFFF;

	// Byte position within a packet, one-hot.
	typedef enum logic [2:0] {
		PH_HEAD = 3'b001,
		PH_XB   = 3'b010,
		PH_YB   = 3'b100
	} phase_t;

	// Assembler status toward the cursor and button logic.
	typedef struct packed {
		logic       last;    // next byte completes a packet
		logic [7:0] head;
		logic [7:0] x_byte;
	} pkt_t;

	typedef struct packed {
		logic [2:0] buttons;
		logic [2:0] clicks;
		logic [2:0] holds;
	} btn_t;

	// 9-bit two's complement delta, pushed a further 255 out on overflow.
	function automatic logic signed [9:0] delta9(input logic [7:0] mag, input logic neg,
		input logic ovf);
		logic signed [9:0] d;
		d = $signed({neg, neg, mag});
		if (ovf) begin
			d = neg ? (d - OVF_EXTRA) : (d + OVF_EXTRA);
		end
		return d;
	endfunction

endpackage

FILE: hdl/pmt_packet_asm.sv
// Packet assembler: collects the three bytes of a PS/2 mouse packet.
// Depends on pmt_pkg.
module pmt_packet_asm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_byte,
	input  logic [7:0]    byte_in,
	output pmt_pkg::pkt_t pkt
);

	pmt_pkg::phase_t phase_q;
	logic [7:0]      head_q;
	logic [7:0]      x_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pmt_pkg::PH_HEAD;
			head_q   <= '0;
			x_byte_q <= '0;
		end else if (step_byte) begin
			unique case (phase_q)
				pmt_pkg::PH_HEAD: begin
					// drop bytes until one carries the sync bit
					if (byte_in[pmt_pkg::SYNC_POS]) begin
						head_q  <= byte_in;
						phase_q <= pmt_pkg::PH_XB;
					end
				end
				pmt_pkg::PH_XB: begin
					x_byte_q <= byte_in;
					phase_q  <= pmt_pkg::PH_YB;
				end
				pmt_pkg::PH_YB: begin
					phase_q <= pmt_pkg::PH_HEAD;
				end
				default: begin
					phase_q <= pmt_pkg::PH_HEAD;
				end
			endcase
		end
	end

	assign pkt.last   = (phase_q == pmt_pkg::PH_YB);
	assign pkt.head   = head_q;
	assign pkt.x_byte = x_byte_q;

endmodule

FILE: hdl/pmt_cursor.sv
// Cursor position: applies packet deltas and clamps to the screen limits.
// Depends on pmt_pkg.
module pmt_cursor #(
	parameter int COORD_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  head,
	input  logic [7:0]  x_byte,
	input  logic [7:0]  y_byte,
	input  logic [11:0] max_x,
	input  logic [11:0] max_y,
	output logic [11:0] cursor_x,
	output logic [11:0] cursor_y
);

	localparam int SUM_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 3;
	localparam logic signed [SUM_W-1:0] COORD_MAX_W = SUM_W'((1 << COORD_BITS) - 1);

	logic [COORD_BITS-1:0] pos_x_q, pos_y_q;
	logic [COORD_BITS-1:0] new_x, new_y;
	logic signed [9:0]     dx, dy;
	logic signed [SUM_W-1:0] sum_x, sum_y;

	function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SUM_W-1:0] v,
		input logic [11:0] lim);
		logic signed [SUM_W-1:0] top;
		logic [COORD_BITS-1:0]   r;
		top = $signed(SUM_W'(lim));
		if (top > COORD_MAX_W) begin
			top = COORD_MAX_W;
		end
		if (v < 0) begin
			r = '0;
		end else if (v > top) begin
			r = COORD_BITS'(top);
		end else begin
			r = COORD_BITS'(v);
		end
		return r;
	endfunction

	always_comb begin
		dx    = pmt_pkg::delta9(x_byte, head[pmt_pkg::XSIGN_POS], head[pmt_pkg::XOVF_POS]);
		dy    = pmt_pkg::delta9(y_byte, head[pmt_pkg::YSIGN_POS], head[pmt_pkg::YOVF_POS]);
		// screen y grows downward, mouse y grows upward
		sum_x = $signed(SUM_W'(pos_x_q)) + SUM_W'(dx);
		sum_y = $signed(SUM_W'(pos_y_q)) - SUM_W'(dy);
		new_x = clamp(sum_x, max_x);
		new_y = clamp(sum_y, max_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= COORD_BITS'(pmt_pkg::POS_RESET);
			pos_y_q <= COORD_BITS'(pmt_pkg::POS_RESET);
		end else if (fire) begin
			pos_x_q <= new_x;
			pos_y_q <= new_y;
		end
	end

	assign cursor_x = 12'(new_x);
	assign cursor_y = 12'(new_y);

endmodule

FILE: hdl/pmt_buttons.sv
// Button tracker: press state, click detection and hold timing per button.
// Depends on pmt_pkg.
module pmt_buttons (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick,
	input  logic          fire,
	input  logic [2:0]    pressed,
	input  logic [15:0]   hold_ms,
	output pmt_pkg::btn_t btn
);

	logic [2:0]  down_q;
	logic [15:0] held_q [3];
	logic [2:0]  clicks, holds;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			clicks[i] = pressed[i] & ~down_q[i];
			holds[i]  = pressed[i] & down_q[i] & (held_q[i] >= hold_ms);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= '0;
			for (int i = 0; i < 3; i++) begin
				held_q[i] <= '0;
			end
		end else if (tick) begin
			for (int i = 0; i < 3; i++) begin
				if (down_q[i] && held_q[i] != pmt_pkg::HELD_SAT) begin
					held_q[i] <= held_q[i] + 16'd1;
				end
			end
		end else if (fire) begin
			down_q <= pressed;
			for (int i = 0; i < 3; i++) begin
				// restart on a new press, clear on release, keep while held
				if (!(pressed[i] && down_q[i])) begin
					held_q[i] <= '0;
				end
			end
		end
	end

	assign btn.buttons = pressed;
	assign btn.clicks  = clicks;
	assign btn.holds   = holds;

endmodule

FILE: hdl/ps2_mouse_packet_tracker_unit.sv
// Top level of the PS/2 mouse packet tracker: input stage, result register,
// configuration registers. Depends on pmt_pkg, pmt_packet_asm, pmt_cursor, pmt_buttons.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one word per mouse byte or per
//     millisecond tick. Bytes build three-byte packets; a head byte without
//     the sync bit is dropped. Ticks age the hold timers of pressed buttons.
//   out channel (out_valid/out_ready/out_data): one word per completed
//     packet with the clamped cursor, button state, click and hold flags.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes max_x,
//     max_y and hold_ms; always ready, write only while the block is idle.
// Throughput: one word per cycle unless a third packet byte waits behind a stalled
// result. A word is registered in the input stage and processed there; a packet's
// result is loaded into the result register when its third byte leaves that stage.
// Stall: the result register holds a word until taken. While it is full and
// stalled, the input stage still passes ticks and non-final bytes; only a
// third packet byte waits, and in_ready then drops until out_ready returns.
// Reset: cursor at (50,50), buttons released, packet assembly at the head
// byte, registers at 1008/752/100.
module ps2_mouse_packet_tracker_unit #(
	parameter int COORD_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pmt_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pmt_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// configuration
	logic [11:0] max_x_q, max_y_q;
	logic [15:0] hold_ms_q;

	// input stage
	logic              valid_s1;
	pmt_pkg::in_word_t word_s1;

	// result register
	logic               out_valid_q;
	pmt_pkg::out_word_t out_q;

	pmt_pkg::pkt_t pkt;
	pmt_pkg::btn_t btn;
	logic [11:0]   cursor_x, cursor_y;
	logic          is_byte_s1, final_s1, can_move, step, step_byte, tick, fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q   <= pmt_pkg::MAX_X_RESET;
			max_y_q   <= pmt_pkg::MAX_Y_RESET;
			hold_ms_q <= pmt_pkg::HOLD_MS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pmt_pkg::REG_MAX_X:   max_x_q   <= cfg_data[11:0];
				pmt_pkg::REG_MAX_Y:   max_y_q   <= cfg_data[11:0];
				pmt_pkg::REG_HOLD_MS: hold_ms_q <= cfg_data;
				default: ;  // unmapped index: drop the write
			endcase
		end
	end

	// A word in the input stage may finish unless it completes a packet while
	// the result register is full and stalled.
	assign is_byte_s1 = (word_s1.kind == pmt_pkg::KIND_BYTE);
	assign final_s1   = valid_s1 && is_byte_s1 && pkt.last;
	assign can_move   = !final_s1 || !out_valid_q || out_ready;
	assign step       = valid_s1 && can_move;
	assign step_byte  = step && is_byte_s1;
	assign tick       = step && (word_s1.kind == pmt_pkg::KIND_TICK);
	assign fire       = step_byte && pkt.last;
	assign in_ready   = !valid_s1 || can_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// advance the payload only on acceptance
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	pmt_packet_asm u_asm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_byte (step_byte),
		.byte_in   (word_s1.data_byte),
		.pkt       (pkt)
	);

	pmt_cursor #(
		.COORD_BITS (COORD_BITS)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.head     (pkt.head),
		.x_byte   (pkt.x_byte),
		.y_byte   (word_s1.data_byte),
		.max_x    (max_x_q),
		.max_y    (max_y_q),
		.cursor_x (cursor_x),
		.cursor_y (cursor_y)
	);

	pmt_buttons u_buttons (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.fire    (fire),
		.pressed (pkt.head[2:0]),
		.hold_ms (hold_ms_q),
		.btn     (btn)
	);

	// Result register: drop the word once taken, load a new one on a packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.cursor_x <= cursor_x;
			out_q.cursor_y <= cursor_y;
			out_q.buttons  <= btn.buttons;
			out_q.clicks   <= btn.clicks;
			out_q.holds    <= btn.holds;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// a completed packet always leaves a result pending
	a_fire_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid)
		else $error("packet completed without a result");

	// the input side only stalls behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without output back-pressure");

	// a button cannot both click and hold, and flags only for pressed buttons
	a_flag_sense: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((out_data.clicks & out_data.holds) == 3'b000) &&
			((out_data.clicks & ~out_data.buttons) == 3'b000) &&
			((out_data.holds & ~out_data.buttons) == 3'b000)))
		else $error("inconsistent button flags");
`endif

endmodule

FILE: test/tb_ps2_mouse_packet_tracker_unit.sv
// Testbench for ps2_mouse_packet_tracker_unit: directed and random mouse bytes and ticks,
// with a built-in tracker model that predicts every packet report and checks it.
// Depends on pmt_pkg and the ps2_mouse_packet_tracker_unit RTL.
module tb_ps2_mouse_packet_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS   = 12;
	localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
	localparam int SETTLE_CYC   = 4;      // pipeline is two deep; leave margin
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 400;    // per random phase, four phases

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	pmt_pkg::in_word_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	pmt_pkg::out_word_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = pmt_pkg::REG_MAX_X;
	logic [15:0]        cfg_data  = '0;

	ps2_mouse_packet_tracker_unit #(.COORD_BITS(COORD_BITS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Tracker model: configuration copy and packet/cursor/button state.
	logic [11:0] lim_x;
	logic [11:0] lim_y;
	logic [15:0] hold_lim;
	int          byte_pos;          // 0 head, 1 x byte, 2 y byte
	logic [7:0]  head_byte;
	logic [7:0]  x_byte;
	int          cur_x;
	int          cur_y;
	logic [2:0]  btn_down;
	logic [15:0] held_cnt [3];

	pmt_pkg::out_word_t report_q [$];      // expected packet reports, oldest first

	int errors;
	int cycles;
	int words_sent;
	int ticks_sent;
	int reports_seen;
	int clicks_seen;
	int holds_seen;

	// Sender burst control.
	int burst_left;
	bit calm_burst;

	// Receiver stall pattern.
	int seg_left;
	bit seg_ready;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter; end the run if something hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$display("timeout after %0d cycles, %0d reports still due", cycles,
				report_q.size());
			$finish;
		end
	end

	// Receiver: alternate ready runs and stalls of random length; some runs are long
	// enough that whole bursts pass without any back-pressure.
	always @(negedge clk) begin
		if (seg_left == 0) begin
			seg_ready = !seg_ready;
			seg_left  = seg_ready ? $urandom_range(1, 40) : $urandom_range(1, 6);
		end
		seg_left--;
		out_ready <= seg_ready;
	end

	function automatic int delta_of(logic [7:0] mag, logic neg, logic ovf);
		int d;
		d = neg ? int'(mag) - 256 : int'(mag);
		if (ovf) begin
			d += neg ? -255 : 255;
		end
		return d;
	endfunction

	function automatic int clamp_to(int v, logic [11:0] lim);
		int top;
		top = (int'(lim) > COORD_TOP) ? COORD_TOP : int'(lim);
		if (v < 0) begin
			return 0;
		end
		if (v > top) begin
			return top;
		end
		return v;
	endfunction

	// Model a register write as the block takes it.
	task automatic apply_register(pmt_pkg::cfg_reg_t idx, logic [15:0] value);
		case (idx)
			pmt_pkg::REG_MAX_X: begin
				lim_x = value[11:0];
			end
			pmt_pkg::REG_MAX_Y: begin
				lim_y = value[11:0];
			end
			pmt_pkg::REG_HOLD_MS: begin
				hold_lim = value;
			end
			default: begin
			end
		endcase
	endtask

	// Advance the tracker by one accepted word; queue a report on each third byte.
	task automatic track_word(pmt_pkg::in_word_t w);
		pmt_pkg::out_word_t rep;
		int                 dx;
		int                 dy;
		if (w.kind == pmt_pkg::KIND_TICK) begin
			// Age every pressed button, saturating.
			for (int i = 0; i < 3; i++) begin
				if (btn_down[i] && held_cnt[i] != pmt_pkg::HELD_SAT) begin
					held_cnt[i]++;
				end
			end
			return;
		end
		case (byte_pos)
			0: begin
				// Drop a head byte without the sync bit.
				if (w.data_byte[pmt_pkg::SYNC_POS]) begin
					head_byte = w.data_byte;
					byte_pos  = 1;
				end
				return;
			end
			1: begin
				x_byte   = w.data_byte;
				byte_pos = 2;
				return;
			end
			default: begin
				byte_pos = 0;
			end
		endcase
		dx = delta_of(x_byte, head_byte[pmt_pkg::XSIGN_POS], head_byte[pmt_pkg::XOVF_POS]);
		dy = delta_of(w.data_byte, head_byte[pmt_pkg::YSIGN_POS],
			head_byte[pmt_pkg::YOVF_POS]);
		cur_x = clamp_to(cur_x + dx, lim_x);
		cur_y = clamp_to(cur_y - dy, lim_y);   // invert y: down is positive
		rep = '0;
		rep.cursor_x = cur_x[11:0];
		rep.cursor_y = cur_y[11:0];
		rep.buttons  = head_byte[2:0];
		for (int i = 0; i < 3; i++) begin
			if (!head_byte[i]) begin
				btn_down[i] = 1'b0;
				held_cnt[i] = '0;
			end else if (btn_down[i]) begin
				if (held_cnt[i] >= hold_lim) begin
					rep.holds[i] = 1'b1;
				end
			end else begin
				// New press: report the click and restart its timer.
				btn_down[i]   = 1'b1;
				held_cnt[i]   = '0;
				rep.clicks[i] = 1'b1;
			end
		end
		report_q.push_back(rep);
	endtask

	// Monitor: check the report leaving the block first, then model what enters.
	// Both are sampled on the same rising edge, so ordering within the step is fixed.
	always @(posedge clk) begin
		pmt_pkg::out_word_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					$error("unexpected report x=%0d y=%0d", out_data.cursor_x,
						out_data.cursor_y);
					errors++;
				end else begin
					want = report_q.pop_front();
					reports_seen++;
					clicks_seen += $countones(want.clicks);
					holds_seen  += $countones(want.holds);
					if (out_data.cursor_x !== want.cursor_x) begin
						$error("cursor_x: expected %0d, got %0d", want.cursor_x,
							out_data.cursor_x);
						errors++;
					end
					if (out_data.cursor_y !== want.cursor_y) begin
						$error("cursor_y: expected %0d, got %0d", want.cursor_y,
							out_data.cursor_y);
						errors++;
					end
					if (out_data.buttons !== want.buttons) begin
						$error("buttons: expected %b, got %b", want.buttons,
							out_data.buttons);
						errors++;
					end
					if (out_data.clicks !== want.clicks) begin
						$error("clicks: expected %b, got %b", want.clicks, out_data.clicks);
						errors++;
					end
					if (out_data.holds !== want.holds) begin
						$error("holds: expected %b, got %b", want.holds, out_data.holds);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(pmt_pkg::cfg_reg_t'(cfg_index), cfg_data);
			end
			if (in_valid && in_ready) begin
				track_word(in_data);
			end
		end
	end

	// Send one word. Valid stays high after acceptance so back-to-back words
	// go out without a gap; a gap lowers it only at the start of a new burst.
	task automatic send_word(logic kind, logic [7:0] value);
		pmt_pkg::in_word_t w;
		int                gap;
		w.kind      = kind;
		w.data_byte = value;
		if (burst_left == 0) begin
			calm_burst = ($urandom_range(0, 3) == 0);
			burst_left = $urandom_range(1, 24);
			gap        = calm_burst ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		if (kind == pmt_pkg::KIND_TICK) begin
			ticks_sent++;
		end
	endtask

	task automatic send_packet(logic [7:0] head, logic [7:0] xb, logic [7:0] yb);
		send_word(pmt_pkg::KIND_BYTE, head);
		send_word(pmt_pkg::KIND_BYTE, xb);
		send_word(pmt_pkg::KIND_BYTE, yb);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_word(pmt_pkg::KIND_TICK, 8'($urandom));
	endtask

	// Drain: hold valid low until every report is out, then let the pipe empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(pmt_pkg::cfg_reg_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(logic [11:0] mx, logic [11:0] my, logic [15:0] hold);
		settle();
		write_reg(pmt_pkg::REG_MAX_X, {4'b0, mx});
		write_reg(pmt_pkg::REG_MAX_Y, {4'b0, my});
		write_reg(pmt_pkg::REG_HOLD_MS, hold);
	endtask

	// Reset values: lost sync, zero and extreme deltas, overflow, ticks inside a packet.
	task automatic test_directed_packets();
		send_word(pmt_pkg::KIND_BYTE, 8'h00);          // head without sync: drop
		send_word(pmt_pkg::KIND_BYTE, 8'hF7);          // all bits but sync: drop
		send_packet(8'h08, 8'h00, 8'h00);     // no motion, no buttons
		send_packet(8'h09, 8'hFF, 8'h01);     // left press, x +255, y up 1
		send_word(pmt_pkg::KIND_TICK, 8'hFF);
		send_word(pmt_pkg::KIND_BYTE, 8'h0A);          // right press, ticks between bytes
		send_word(pmt_pkg::KIND_TICK, 8'h00);
		send_word(pmt_pkg::KIND_BYTE, 8'h80);
		send_word(pmt_pkg::KIND_TICK, 8'h5A);
		send_word(pmt_pkg::KIND_BYTE, 8'h7F);
		send_packet(8'h1C, 8'h00, 8'h00);     // sign with zero magnitude: -256
		send_packet(8'hFF, 8'h00, 8'h00);     // both overflows negative, all buttons
		send_packet(8'hCF, 8'hFF, 8'hFF);     // both overflows positive
	endtask

	// Hold time short, zero and maximal.
	task automatic test_hold_timing();
		set_limits(12'd1008, 12'd752, 16'd3);
		send_packet(8'h09, 8'h01, 8'h01);     // left still down from before: no click
		send_ticks(2);
		send_packet(8'h09, 8'h00, 8'h00);     // held 2 < 3: no hold
		send_ticks(1);
		send_packet(8'h0B, 8'h00, 8'h00);     // left hold, right click
		send_packet(8'h08, 8'h00, 8'h00);     // release all
		set_limits(12'd1008, 12'd752, 16'd0);
		send_packet(8'h0F, 8'h02, 8'hFE);     // click all three
		send_packet(8'h0F, 8'h00, 8'h00);     // hold all at once
		set_limits(12'd1008, 12'd752, 16'hFFFF);
		send_ticks(20);
		send_packet(8'h0F, 8'h00, 8'h00);     // still down, far from hold
		send_packet(8'h08, 8'h00, 8'h00);
	endtask

	// Cursor at both ends of the register range.
	task automatic test_cursor_limits();
		set_limits(12'd0, 12'd0, 16'd100);
		send_packet(8'h08, 8'h7F, 8'h80);
		send_packet(8'hC8, 8'hFF, 8'h00);
		set_limits(12'hFFF, 12'hFFF, 16'd100);
		// Walk right by 510 and down by 255 a packet; x clamps at the top.
		repeat (9) send_packet(8'h68, 8'hFF, 8'h01);
		send_packet(8'h08, 8'h00, 8'h00);
		repeat (9) send_packet(8'hD8, 8'h01, 8'hFF);
	endtask

	function automatic logic [11:0] pick_limit();
		case ($urandom_range(0, 3))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom_range(1, 4094));
		endcase
	endfunction

	// Mostly well-formed packets with persistent buttons and ticks in between;
	// the rest is stray bytes and cut-off packets that knock the framing about.
	task automatic test_random_traffic();
		logic [2:0]  btn;
		logic [7:0]  head;
		logic [15:0] hold;
		int          count;
		int          nt;
		btn = '0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: hold = 16'd0;
				1: hold = 16'hFFFF;
				default: hold = 16'($urandom_range(1, 30));
			endcase
			set_limits(pick_limit(), pick_limit(), hold);
			count = 0;
			while (count < RANDOM_WORDS) begin
				for (int i = 0; i < 3; i++) begin
					if ($urandom_range(0, 3) == 0) begin
						btn[i] = !btn[i];
					end
				end
				head = 8'($urandom);
				head[pmt_pkg::SYNC_POS] = 1'b1;
				head[2:0] = btn;
				// Keep overflow rare so the cursor spends time away from the rails.
				if ($urandom_range(0, 7) != 0) begin
					head[pmt_pkg::XOVF_POS] = 1'b0;
					head[pmt_pkg::YOVF_POS] = 1'b0;
				end
				case ($urandom_range(0, 11))
					0: begin
						send_word(pmt_pkg::KIND_BYTE, 8'($urandom));   // stray byte
						count++;
					end
					1: begin
						send_word(pmt_pkg::KIND_BYTE, head);           // cut-off packet
						send_word(pmt_pkg::KIND_BYTE, 8'($urandom));
						count += 2;
					end
					default: begin
						send_packet(head, 8'($urandom), 8'($urandom));
						count += 3;
					end
				endcase
				if ($urandom_range(0, 1) == 0) begin
					nt = $urandom_range(1, 8);
					send_ticks(nt);
					count += nt;
				end
			end
		end
	endtask

	initial begin
		lim_x    = pmt_pkg::MAX_X_RESET;
		lim_y    = pmt_pkg::MAX_Y_RESET;
		hold_lim = pmt_pkg::HOLD_MS_RESET;
		byte_pos = 0;
		head_byte = '0;
		x_byte   = '0;
		cur_x    = pmt_pkg::POS_RESET;
		cur_y    = pmt_pkg::POS_RESET;
		btn_down = '0;
		for (int i = 0; i < 3; i++) begin
			held_cnt[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_packets();
		test_hold_timing();
		test_cursor_limits();
		test_random_traffic();
		settle();

		$display("sent %0d words (%0d ticks), checked %0d reports", words_sent, ticks_sent,
			reports_seen);
		$display("saw %0d clicks and %0d holds across ten register settings",
			clicks_seen, holds_seen);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pmt_pkg.sv
hdl/pmt_packet_asm.sv
hdl/pmt_cursor.sv
hdl/pmt_buttons.sv
hdl/ps2_mouse_packet_tracker_unit.sv
test/tb_ps2_mouse_packet_tracker_unit.sv
